>>> sv/bfr_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap font renderer package
// Shared constants, register map and a small helper for the glyph blitter.
// ----------------------------------------------------------------------------
package bfr_pkg;

	// Default sizes of the glyph store.
	localparam int MAX_GLYPHS_DEF     = 256;
	localparam int MAX_GLYPH_ROWS_DEF = 32;

	// Widest glyph row that the store and the mask carry.
	localparam int MAX_GLYPH_WIDTH = 16;
	localparam int WMAX            = (MAX_GLYPH_WIDTH < 16) ? MAX_GLYPH_WIDTH : 16;

	// Stream word layout.
	localparam int S_TDATA_W = 80;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 80;

	// Configuration port.
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_FRAME_BASE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LINE_PITCH   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GLYPH_COUNT  = 3'd4;

	localparam logic [31:0] FRAME_BASE_RST   = 32'd0;
	localparam logic [15:0] LINE_PITCH_RST   = 16'd4096;
	localparam logic [4:0]  GLYPH_WIDTH_RST  = 5'd8;
	localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd16;
	localparam logic [8:0]  GLYPH_COUNT_RST  = 9'd256;

	// Operations carried in tuser.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// Control characters.
	localparam logic [7:0] CODE_CR = 8'd13;
	localparam logic [7:0] CODE_LF = 8'd10;

	// Cursor step that stops at the top of its range.
	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		logic [7:0] r;
		r = (v == 8'hFF) ? v : v + 8'd1;
		return r;
	endfunction

endpackage

>>> sv/bfr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/bitmap_font_text_renderer_top.sv
// ----------------------------------------------------------------------------
// Bitmap font text renderer
// Loads a glyph store and turns character codes into framebuffer row writes.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Word contents
//  s_axis   | in        | tuser: opcode; tdata: code, color, first, start_col,
//           |           |   start_row, load_row, row_bits
//  m_axis   | out       | tdata: pixel_address, pixel_mask, pixel_color;
//           |           |   tlast: last_row
//  apb      | in/out    | frame_base, line_pitch, glyph_width, glyph_height,
//           |           |   glyph_count at byte addresses 0, 4, 8, 12, 16
//
// A load, a carriage return or a line feed leaves the input ready. A drawn
// character holds the input through accept, setup states MULT and BASE,
// then one glyph store read per row; the single read port gives one row
// per cycle while m_axis is not stalled. A two-word output buffer lets rows
// keep flowing while m_axis is stalled; reads pause when it would overflow.
// Reset clears the cursor and control and sets the registers to defaults;
// the glyph store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer_top #(
	parameter int MAX_GLYPHS     = bfr_pkg::MAX_GLYPHS_DEF,
	parameter int MAX_GLYPH_ROWS = bfr_pkg::MAX_GLYPH_ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// code[7:0], color[39:8], first[40], start_col[48:41], start_row[56:49],
	// load_row[61:57], row_bits[77:62], zero fill
	input  logic [bfr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// opcode[0]
	input  logic [bfr_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// pixel_address[31:0], pixel_mask[47:32], pixel_color[79:48]
	output logic [bfr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	output logic                           m_axis_tlast,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bfr_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import bfr_pkg::*;

	localparam int STORE_DEPTH = MAX_GLYPHS * MAX_GLYPH_ROWS;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int HMAX        = (MAX_GLYPH_ROWS < 32) ? MAX_GLYPH_ROWS : 32;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MULT = 4'b0010,
		ST_BASE = 4'b0100,
		ST_ROWS = 4'b1000
	} state_t;

	typedef struct packed {
		logic [31:0] color;
		logic [15:0] mask;
		logic [31:0] addr;
		logic        last;
	} row_t;

	// Configuration registers.
	logic [31:0] frame_base_q;
	logic [15:0] line_pitch_q;
	logic [4:0]  glyph_width_q;
	logic [5:0]  glyph_height_q;
	logic [8:0]  glyph_count_q;

	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	// Input fields.
	logic        in_opcode;
	logic [7:0]  in_code;
	logic [31:0] in_color;
	logic        in_first;
	logic [7:0]  in_start_col;
	logic [7:0]  in_start_row;
	logic [4:0]  in_load_row;
	logic [15:0] in_row_bits;

	logic        in_acc;
	logic [7:0]  cur_col;
	logic [7:0]  cur_row;
	logic [7:0]  glyph_sel;
	logic [4:0]  w;
	logic [5:0]  h;

	state_t      state_q;
	logic [7:0]  cursor_col_q;
	logic [7:0]  cursor_row_q;
	logic [7:0]  glyph_q;
	logic [31:0] color_q;
	logic [13:0] rowh_q;
	logic [12:0] coloff_q;
	logic [29:0] lineoff_q;
	logic [ADDR_W-1:0] gbase_q;
	logic [31:0] addr_q;
	logic [5:0]  r_q;
	logic        row_last;

	// Store ports.
	logic              st_we;
	logic [ADDR_W-1:0] st_waddr;
	logic              st_re;
	logic [ADDR_W-1:0] st_raddr;
	logic [15:0]       st_rdata;

	// Read pipeline and output buffer.
	logic        rd_vld_s1;
	logic [31:0] addr_s1;
	logic [31:0] color_s1;
	logic        last_s1;
	logic [15:0] mask;
	row_t        new_row;
	row_t        head_q;
	row_t        skid_q;
	logic [1:0]  cnt_q;
	logic        pop;
	logic        issue_ok;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q   <= FRAME_BASE_RST;
			line_pitch_q   <= LINE_PITCH_RST;
			glyph_width_q  <= GLYPH_WIDTH_RST;
			glyph_height_q <= GLYPH_HEIGHT_RST;
			glyph_count_q  <= GLYPH_COUNT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_FRAME_BASE:   frame_base_q   <= pwdata;
				REG_LINE_PITCH:   line_pitch_q   <= pwdata[15:0];
				REG_GLYPH_WIDTH:  glyph_width_q  <= pwdata[4:0];
				REG_GLYPH_HEIGHT: glyph_height_q <= pwdata[5:0];
				REG_GLYPH_COUNT:  glyph_count_q  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_FRAME_BASE:   prdata = frame_base_q;
			REG_LINE_PITCH:   prdata = {16'd0, line_pitch_q};
			REG_GLYPH_WIDTH:  prdata = {27'd0, glyph_width_q};
			REG_GLYPH_HEIGHT: prdata = {26'd0, glyph_height_q};
			REG_GLYPH_COUNT:  prdata = {23'd0, glyph_count_q};
			default:          prdata = 32'd0;
		endcase
	end

	// ---------------- input decode ----------------
	assign in_opcode    = s_axis_tuser[0];
	assign in_code      = s_axis_tdata[7:0];
	assign in_color     = s_axis_tdata[39:8];
	assign in_first     = s_axis_tdata[40];
	assign in_start_col = s_axis_tdata[48:41];
	assign in_start_row = s_axis_tdata[56:49];
	assign in_load_row  = s_axis_tdata[61:57];
	assign in_row_bits  = s_axis_tdata[77:62];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign cur_col = in_first ? in_start_col : cursor_col_q;
	assign cur_row = in_first ? in_start_row : cursor_row_q;

	always_comb begin
		if (glyph_width_q == 5'd0) begin
			w = 5'd1;
		end else if (glyph_width_q > 5'(WMAX)) begin
			w = 5'(WMAX);
		end else begin
			w = glyph_width_q;
		end
		if (glyph_height_q == 6'd0) begin
			h = 6'd1;
		end else if (glyph_height_q > 6'(HMAX)) begin
			h = 6'(HMAX);
		end else begin
			h = glyph_height_q;
		end
	end

	assign glyph_sel = (({1'b0, in_code} < glyph_count_q) && (int'(in_code) < MAX_GLYPHS))
		? in_code : 8'd0;

	// Loads go straight into the store; out-of-range loads are dropped.
	assign st_we    = in_acc && (in_opcode == OP_LOAD) && (int'(in_code) < MAX_GLYPHS)
		&& (int'(in_load_row) < MAX_GLYPH_ROWS);
	assign st_waddr = ADDR_W'(int'(in_code) * MAX_GLYPH_ROWS + int'(in_load_row));

	// ---------------- character sequencer ----------------
	assign pop      = m_axis_tvalid && m_axis_tready;
	// Never let the buffer plus the read in flight exceed two words.
	assign issue_ok = (cnt_q == 2'd0)
		|| ((cnt_q == 2'd1) && (!rd_vld_s1 || pop))
		|| ((cnt_q == 2'd2) && pop && !rd_vld_s1);
	assign row_last = (r_q == (h - 6'd1));
	assign st_re    = (state_q == ST_ROWS) && issue_ok;
	assign st_raddr = gbase_q + ADDR_W'(r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cursor_col_q <= 8'd0;
			cursor_row_q <= 8'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_opcode == OP_DRAW)) begin
						if (in_code == CODE_CR) begin
							cursor_col_q <= 8'd0;
							cursor_row_q <= cur_row;
						end else if (in_code == CODE_LF) begin
							cursor_col_q <= 8'd0;
							cursor_row_q <= sat_inc(cur_row);
						end else begin
							cursor_col_q <= sat_inc(cur_col);
							cursor_row_q <= cur_row;
							state_q      <= ST_MULT;
						end
					end
				end
				ST_MULT: state_q <= ST_BASE;
				ST_BASE: state_q <= ST_ROWS;
				ST_ROWS: begin
					if (issue_ok && row_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			glyph_q  <= glyph_sel;
			color_q  <= in_color;
			rowh_q   <= 14'(cur_row) * 14'(h);
			coloff_q <= 13'(cur_col) * (13'(w) + 13'd1);
		end
		if (state_q == ST_MULT) begin
			lineoff_q <= 30'(rowh_q) * 30'(line_pitch_q);
			gbase_q   <= ADDR_W'(int'(glyph_q) * MAX_GLYPH_ROWS);
		end
		if (state_q == ST_BASE) begin
			addr_q <= frame_base_q + 32'(lineoff_q) + {17'd0, coloff_q, 2'b00};
			r_q    <= 6'd0;
		end else if (st_re) begin
			addr_q <= addr_q + 32'(line_pitch_q);
			r_q    <= r_q + 6'd1;
		end
		if (st_re) begin
			addr_s1  <= addr_q;
			color_s1 <= color_q;
			last_s1  <= row_last;
		end
	end

	bfr_ram #(
		.WIDTH (16),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (in_row_bits),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// ---------------- mask and output buffer ----------------
	// The leftmost pixel sits in bit w-1 of the stored row and goes to mask bit 0.
	always_comb begin
		logic [4:0] idx;
		for (int i = 0; i < 16; i++) begin
			idx = w - 5'd1 - 5'(i);
			mask[i] = (5'(i) < w) ? st_rdata[idx[3:0]] : 1'b0;
		end
	end

	always_comb begin
		new_row.color = color_s1;
		new_row.mask  = mask;
		new_row.addr  = addr_s1;
		new_row.last  = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			cnt_q     <= 2'd0;
		end else begin
			rd_vld_s1 <= st_re;
			case (cnt_q)
				2'd0: if (rd_vld_s1) cnt_q <= 2'd1;
				2'd1: if (rd_vld_s1 && !pop) begin
					cnt_q <= 2'd2;
				end else if (!rd_vld_s1 && pop) begin
					cnt_q <= 2'd0;
				end
				2'd2: if (pop && !rd_vld_s1) cnt_q <= 2'd1;
				default: cnt_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: if (rd_vld_s1) head_q <= new_row;
			2'd1: if (rd_vld_s1) begin
				if (pop) begin
					head_q <= new_row;
				end else begin
					skid_q <= new_row;
				end
			end
			2'd2: if (pop) begin
				head_q <= skid_q;
				if (rd_vld_s1) begin
					skid_q <= new_row;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = {head_q.color, head_q.mask, head_q.addr};
	assign m_axis_tlast  = head_q.last;

endmodule

>>> sv/bfr_chk.sv
// ----------------------------------------------------------------------------
// Bitmap font renderer port checker
// Watches the top level's ports and flags sequencing errors.
// ----------------------------------------------------------------------------
module bfr_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [bfr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	input logic [bfr_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [bfr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input logic                           m_axis_tlast
);
	import bfr_pkg::*;

	logic in_acc;
	logic quick_op;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign quick_op = (s_axis_tuser[0] == OP_LOAD) || (s_axis_tdata[7:0] == CODE_CR)
		|| (s_axis_tdata[7:0] == CODE_LF);

	// A stalled output word must not change under the consumer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// A drawn glyph takes the sequencer out of idle, so the input is not ready once it is accepted.
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !quick_op |=> !s_axis_tready)
		else $error("input accepted during glyph setup");

	// Loads and cursor controls leave the input ready for the next word.
	a_quick_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && quick_op |=> s_axis_tready)
		else $error("input blocked after a single-cycle word");

endmodule

bind bitmap_font_text_renderer_top bfr_chk u_bfr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
